// ----- rtl/misu_pkg.sv -----
// ----------------------------------------------------------------------------
// misu_pkg
// shared widths, register indexes and defaults for the ising spin update block
// ----------------------------------------------------------------------------
package misu_pkg;

	localparam int LATTICE_SIDE_DEF = 64;

	localparam int SITE_W    = 12;
	localparam int SITE_SPAN = 4096;
	localparam int FRAC_W    = 32;
	localparam int ENERGY_W  = 15;
	localparam int MAG_W     = 14;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 32;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 12;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = 28;

	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_GAP4   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_GAP8   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLIPS_ENABLED = 2'd2;

	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_FILL   = 1'b1;

endpackage

// ----- rtl/metropolis_ising_spin_update.sv -----
// ----------------------------------------------------------------------------
// metropolis_ising_spin_update
// metropolis single-spin update on a periodic square lattice with running
// energy and magnetization totals, plus a whole-lattice fill
// ----------------------------------------------------------------------------
//
//  channel  dir  word contents
//  s_*      in   tuser: mode; tdata: site_index[11:0] random_fraction[43:12]
//                fill_spin[44]
//  m_*      out  tdata: energy[14:0] magnetization[28:15] flipped[29]
//  cfg_*    in   cfg_index selects accept_gap4, accept_gap8, flips_enabled
//
//  update word: accept, then the site split in five steps, four of them on the
//  shared multiplier, then the five spin reads on the single read port, then
//  evaluate and write, then the output register
//  fill word: one site written per cycle
//  after reset the lattice is set to all up, s_tready low meanwhile; a waiting
//  result holds the block in its output state
//
module metropolis_ising_spin_update
	import misu_pkg::*;
#(
	parameter int LATTICE_SIDE = LATTICE_SIDE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // site_index, random_fraction, fill_spin
	input  logic                 s_tuser,   // mode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // energy, magnetization, flipped
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;
	localparam int AW = $clog2(SITE_COUNT);
	localparam int RW = $clog2(LATTICE_SIDE);
	localparam bit MOD_ON = (SITE_COUNT < SITE_SPAN);

	// reciprocal constants: floor(x / d) == (x * m) >> k for any 12-bit x
	localparam int KN = MOD_ON ? SITE_W + $clog2(SITE_COUNT) : 0;
	localparam longint MN_L = MOD_ON ?
		((longint'(1) << KN) + longint'(SITE_COUNT) - 1) / longint'(SITE_COUNT) : 0;
	localparam int KS = SITE_W + RW;
	localparam longint MS_L =
		((longint'(1) << KS) + longint'(LATTICE_SIDE) - 1) / longint'(LATTICE_SIDE);

	localparam logic [MUL_B_W-1:0] MN_B   = MUL_B_W'(MN_L);
	localparam logic [MUL_B_W-1:0] MS_B   = MUL_B_W'(MS_L);
	localparam logic [MUL_B_W-1:0] N_B    = MUL_B_W'(SITE_COUNT);
	localparam logic [MUL_B_W-1:0] SIDE_B = MUL_B_W'(LATTICE_SIDE);

	localparam logic [ENERGY_W-1:0] E_RESET  = ENERGY_W'(-2 * SITE_COUNT);
	localparam logic [MAG_W-1:0]    MAG_UP   = MAG_W'(SITE_COUNT);
	localparam logic [MAG_W-1:0]    MAG_DOWN = MAG_W'(-SITE_COUNT);

	localparam logic [AW-1:0] SITE_LAST  = AW'(SITE_COUNT - 1);
	localparam logic [AW-1:0] WRAP_ROW   = AW'(SITE_COUNT - LATTICE_SIDE);
	localparam logic [AW-1:0] SIDE_A     = AW'(LATTICE_SIDE);
	localparam logic [AW-1:0] WRAP_COL   = AW'(LATTICE_SIDE - 1);
	localparam logic [AW-1:0] ONE_A      = AW'(1);
	localparam logic [RW-1:0] EDGE_LAST  = RW'(LATTICE_SIDE - 1);

	// site split steps
	localparam logic [2:0] CS_QUOT_N = 3'd0;
	localparam logic [2:0] CS_PROD_N = 3'd1;
	localparam logic [2:0] CS_QUOT_S = 3'd2;
	localparam logic [2:0] CS_PROD_S = 3'd3;
	localparam logic [2:0] CS_COL    = 3'd4;

	// read slots
	localparam logic [2:0] RD_CENTER = 3'd0;
	localparam logic [2:0] RD_UP     = 3'd1;
	localparam logic [2:0] RD_DOWN   = 3'd2;
	localparam logic [2:0] RD_LEFT   = 3'd3;
	localparam logic [2:0] RD_RIGHT  = 3'd4;
	localparam logic [2:0] RD_DONE   = 3'd5;

	typedef enum logic [5:0] {
		ST_SWEEP = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_CALC  = 6'b000100,
		ST_READ  = 6'b001000,
		ST_EVAL  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;

	logic [FRAC_W-1:0]   gap4_q;
	logic [FRAC_W-1:0]   gap8_q;
	logic                flips_en_q;

	logic [SITE_W-1:0]   x_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [SITE_W-1:0]   site_q;
	logic [RW-1:0]       row_q;
	logic [RW-1:0]       col_q;
	logic [MUL_P_W-1:0]  prod_q;
	logic [2:0]          calc_q;
	logic [2:0]          rd_q;
	logic                center_q;
	logic [2:0]          up_cnt_q;
	logic                flip_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [MAG_W-1:0]    mag_q;
	logic [AW-1:0]       sweep_q;
	logic                sweep_val_q;
	logic                sweep_emit_q;
	logic                rd_data_q;
	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic                mem [SITE_COUNT];

	// shared multiplier
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [MUL_P_W-1:0]  mul_p;
	logic [SITE_W-1:0]   quot_n;
	logic [SITE_W-1:0]   site_v;
	logic [RW-1:0]       row_v;

	assign quot_n = SITE_W'(prod_q >> KN);
	assign site_v = MOD_ON ? (x_q - prod_q[SITE_W-1:0]) : x_q;
	assign row_v  = RW'(prod_q >> KS);

	always_comb begin
		case (calc_q)
			CS_QUOT_N: begin
				mul_a = x_q;
				mul_b = MN_B;
			end
			CS_PROD_N: begin
				mul_a = quot_n;
				mul_b = N_B;
			end
			CS_QUOT_S: begin
				mul_a = site_v;
				mul_b = MS_B;
			end
			CS_PROD_S: begin
				mul_a = MUL_A_W'(row_v);
				mul_b = SIDE_B;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

	// neighbor addresses with periodic wrap
	logic [AW-1:0] site_a;
	logic [AW-1:0] up_a;
	logic [AW-1:0] down_a;
	logic [AW-1:0] left_a;
	logic [AW-1:0] right_a;
	logic [AW-1:0] rd_addr;

	assign site_a  = AW'(site_q);
	assign up_a    = (row_q == '0) ? site_a + WRAP_ROW : site_a - SIDE_A;
	assign down_a  = (row_q == EDGE_LAST) ? site_a - WRAP_ROW : site_a + SIDE_A;
	assign left_a  = (col_q == '0) ? site_a + WRAP_COL : site_a - ONE_A;
	assign right_a = (col_q == EDGE_LAST) ? site_a - WRAP_COL : site_a + ONE_A;

	always_comb begin
		case (rd_q)
			RD_CENTER: rd_addr = site_a;
			RD_UP:     rd_addr = up_a;
			RD_DOWN:   rd_addr = down_a;
			RD_LEFT:   rd_addr = left_a;
			RD_RIGHT:  rd_addr = right_a;
			default:   rd_addr = site_a;
		endcase
	end

	// acceptance
	logic [2:0]          agree;
	logic                accept;
	logic [ENERGY_W-1:0] gap;

	assign agree  = center_q ? up_cnt_q : 3'd4 - up_cnt_q;
	assign gap    = ENERGY_W'({agree, 2'b00}) - ENERGY_W'(8);
	assign accept = flips_en_q && ((agree <= 3'd2) ||
		((agree == 3'd3) && (frac_q < gap4_q)) ||
		((agree == 3'd4) && (frac_q < gap8_q)));

	// lattice memory port
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          wr_data;

	assign wr_en   = (state_q == ST_SWEEP) || ((state_q == ST_EVAL) && accept);
	assign wr_addr = (state_q == ST_SWEEP) ? sweep_q : site_a;
	assign wr_data = (state_q == ST_SWEEP) ? sweep_val_q : !center_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap4_q     <= '0;
			gap8_q     <= '0;
			flips_en_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACCEPT_GAP4:   gap4_q     <= cfg_data;
				CFG_ACCEPT_GAP8:   gap8_q     <= cfg_data;
				CFG_FLIPS_ENABLED: flips_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_q      <= '0;
			sweep_val_q  <= 1'b1;
			sweep_emit_q <= 1'b0;
			calc_q       <= CS_QUOT_N;
			rd_q         <= RD_CENTER;
			energy_q     <= E_RESET;
			mag_q        <= MAG_UP;
			m_tvalid_q   <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					if (sweep_q == SITE_LAST) begin
						sweep_q <= '0;
						if (sweep_emit_q) begin
							energy_q <= E_RESET;
							mag_q    <= sweep_val_q ? MAG_UP : MAG_DOWN;
							state_q  <= ST_OUT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						sweep_q <= sweep_q + ONE_A;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == MODE_FILL) begin
							sweep_val_q  <= s_tdata[44];
							sweep_emit_q <= 1'b1;
							state_q      <= ST_SWEEP;
						end else begin
							calc_q  <= CS_QUOT_N;
							state_q <= ST_CALC;
						end
					end
				end
				ST_CALC: begin
					calc_q <= calc_q + 3'd1;
					if (calc_q == CS_COL) begin
						rd_q    <= RD_CENTER;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					rd_q <= rd_q + 3'd1;
					if (rd_q == RD_DONE) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (accept) begin
						energy_q <= energy_q + gap;
						mag_q    <= center_q ? mag_q - MAG_W'(2) : mag_q + MAG_W'(2);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && s_tvalid) begin
			x_q    <= s_tdata[SITE_W-1:0];
			frac_q <= s_tdata[SITE_W+FRAC_W-1:SITE_W];
			flip_q <= 1'b0;
		end
		if (state_q == ST_CALC) begin
			prod_q <= mul_p;
			case (calc_q)
				CS_QUOT_S: site_q <= site_v;
				CS_PROD_S: row_q  <= row_v;
				CS_COL:    col_q  <= RW'(site_q - prod_q[SITE_W-1:0]);
				default: ;
			endcase
		end
		if (state_q == ST_READ) begin
			if (rd_q == RD_UP) begin
				center_q <= rd_data_q;
				up_cnt_q <= 3'd0;
			end else if (rd_q != RD_CENTER) begin
				up_cnt_q <= up_cnt_q + 3'(rd_data_q);
			end
		end
		if (state_q == ST_EVAL) begin
			flip_q <= accept;
		end
		if ((state_q == ST_OUT) && out_free) begin
			m_tdata_q <= {2'b00, flip_q, mag_q, energy_q};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef NO_ASSERTIONS
	// energy moves by multiples of four, magnetization by two
	a_energy_residue: assert property (@(posedge clk) disable iff (!arst_n)
		energy_q[1:0] == E_RESET[1:0])
		else $error("energy total left its residue class");

	a_mag_parity: assert property (@(posedge clk) disable iff (!arst_n)
		mag_q[0] == MAG_UP[0])
		else $error("magnetization total changed parity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("ready right after taking a word");

	a_energy_source: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(energy_q) |-> ($past(state_q) == ST_EVAL || $past(state_q) == ST_SWEEP))
		else $error("energy total changed outside evaluate or fill");
`endif

endmodule
